@@ rtl/mswt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mswt_pkg
// Shared types and constants of the mean shift window tracker.
// ----------------------------------------------------------------------------
package mswt_pkg;

  localparam int MAP_COLS_MAX_DEF = 256;
  localparam int MAP_ROWS_MAX_DEF = 256;

  // configuration register indexes
  localparam logic [2:0] REG_MAP_ROWS   = 3'd0;
  localparam logic [2:0] REG_MAP_COLS   = 3'd1;
  localparam logic [2:0] REG_WIN_WIDTH  = 3'd2;
  localparam logic [2:0] REG_WIN_HEIGHT = 3'd3;
  localparam logic [2:0] REG_ITERATIONS = 3'd4;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_RUN   = 1'b1;

  // divider widths: numerator magnitude and divisor
  localparam int DIV_NW = 44;
  localparam int DIV_DW = 34;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DIVX,
    ST_WAITX,
    ST_DIVY,
    ST_WAITY,
    ST_UPDATE,
    ST_OUT
  } state_t;

  // handshake between sequencer and divider
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage : mswt_pkg
`default_nettype wire

@@ rtl/mswt_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mswt_div
// Radix-2 restoring divider: one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module mswt_div
  import mswt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire div_ctl_t              ctl,
  input  wire logic [DIV_NW-1:0]     num,
  input  wire logic [DIV_DW-1:0]     den,
  output      div_sts_t              sts,
  output      logic [DIV_NW-1:0]     quo
);

  localparam int CW = $clog2(DIV_NW + 1);

  logic [DIV_NW-1:0] q_r, q_nxt;
  logic [DIV_DW:0]   rem_r, rem_nxt;
  logic [DIV_DW-1:0] den_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_DW:0]   trial;

  // load the operands on start, else one shift-subtract step while busy
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DIV_DW-1:0], q_r[DIV_NW-1]};
    if (ctl.start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = CW'(DIV_NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = {q_r[DIV_NW-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt  = trial - {1'b0, den_r};
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (ctl.start) den_r <= den;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = q_r;

  // a finished division never overlaps a running one
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == CW'(1) && !ctl.start) |=> done_r)
    else $error("divider missed done");
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> cnt_r != '0)
    else $error("divider count underflow");

endmodule : mswt_div
`default_nettype wire

@@ rtl/mean_shift_window_tracker_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mean_shift_window_tracker_core
// Density map memory with a mean shift window tracking sequencer.
// ----------------------------------------------------------------------------
// A write item (action 0) stores one density sample when its row and column
// lie inside the map memory. A run item (action 1) reads the window from the
// map memory one sample per cycle and, per iteration, divides twice on a
// bit-serial divider; an iteration over a zero-mass window skips both
// divides. The single read port of the map memory and the serial divider
// bound how fast a run completes. Map entries never written read as
// undefined.
module mean_shift_window_tracker_core
  import mswt_pkg::*;
#(
  parameter int MAP_COLS_MAX = mswt_pkg::MAP_COLS_MAX_DEF,
  parameter int MAP_ROWS_MAX = mswt_pkg::MAP_ROWS_MAX_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_sample_row,
  input  wire logic [7:0]  in_sample_col,
  input  wire logic [15:0] in_density,
  input  wire logic [7:0]  in_start_x,
  input  wire logic [7:0]  in_start_y,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [7:0]  out_win_x,
  output      logic [7:0]  out_win_y,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);

  localparam int CB = $clog2(MAP_COLS_MAX);
  localparam int RB = $clog2(MAP_ROWS_MAX);
  localparam int AB = CB + RB;
  localparam int DEPTH = 1 << AB;
  localparam int CWB = (CB > 8 ? CB : 8) + 1;
  localparam int RWB = (RB > 8 ? RB : 8) + 1;

  // ---------------- configuration registers ----------------
  logic [8:0] map_rows_r, map_cols_r, win_w_r, win_h_r;
  logic [7:0] iters_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_rows_r <= 9'd256;
      map_cols_r <= 9'd256;
      win_w_r    <= 9'd32;
      win_h_r    <= 9'd32;
      iters_r    <= 8'd10;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAP_ROWS:   map_rows_r <= cfg_data;
        REG_MAP_COLS:   map_cols_r <= cfg_data;
        REG_WIN_WIDTH:  win_w_r    <= cfg_data;
        REG_WIN_HEIGHT: win_h_r    <= cfg_data;
        REG_ITERATIONS: iters_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // effective sizes (13 bits covers 4096)
  logic [12:0] rows_e, cols_e, w_e, h_e, xmax, ymax;
  always_comb begin
    rows_e = (map_rows_r == '0) ? 13'd1 :
             (13'(map_rows_r) > 13'(MAP_ROWS_MAX)) ? 13'(MAP_ROWS_MAX) : 13'(map_rows_r);
    cols_e = (map_cols_r == '0) ? 13'd1 :
             (13'(map_cols_r) > 13'(MAP_COLS_MAX)) ? 13'(MAP_COLS_MAX) : 13'(map_cols_r);
    w_e = (win_w_r == '0) ? 13'd1 : (13'(win_w_r) > cols_e) ? cols_e : 13'(win_w_r);
    h_e = (win_h_r == '0) ? 13'd1 : (13'(win_h_r) > rows_e) ? rows_e : 13'(win_h_r);
    xmax = cols_e - w_e;
    ymax = rows_e - h_e;
  end

  // ---------------- density map memory ----------------
  logic [15:0] mem [DEPTH];
  logic [15:0] rd_q;
  logic        mem_we;
  logic [AB-1:0] mem_wa, mem_ra;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= in_density;
    rd_q <= mem[mem_ra];
  end

  // ---------------- sequencer ----------------
  state_t st_r, st_nxt;
  logic [12:0] cx_r, cx_nxt, cy_r, cy_nxt;      // corner
  logic [12:0] ix_r, ix_nxt, iy_r, iy_nxt;      // scan offsets
  logic [12:0] px_r, px_nxt, py_r, py_nxt;      // offsets of the pending read
  logic        pv_r, pv_nxt;                    // read in flight
  logic [7:0]  it_r, it_nxt;
  logic [31:0] mass_r, mass_nxt;
  logic [39:0] mx_r, mx_nxt, my_r, my_nxt;
  logic [12:0] tx_r, tx_nxt;
  logic        txn_r, txn_nxt;
  logic [7:0]  ox_r, ox_nxt, oy_r, oy_nxt;
  logic        out_v_r, out_v_nxt;

  // divider
  div_ctl_t dctl;
  div_sts_t dsts;
  logic [DIV_NW-1:0] dnum, dquo;
  logic [DIV_DW-1:0] dden;

  // signed numerator: 2*moment + (2*cur - size)*mass
  logic signed [46:0] nsx;
  logic [39:0] mom_sel;
  logic [12:0] cur_sel, sz_sel;
  logic signed [14:0] off_s;
  logic signed [46:0] prod;
  logic        nneg;
  logic [45:0] nmag;
  logic [DIV_DW-1:0] d2;
  logic signed [15:0] q_s;
  logic [13:0] adx, ady;
  logic signed [15:0] tx_s;
  logic        accept_mv;

  assign in_stall  = (st_r != ST_IDLE) || out_v_r;
  assign out_valid = out_v_r;
  assign out_win_x = ox_r;
  assign out_win_y = oy_r;

  always_comb begin
    mom_sel = (st_r == ST_DIVX) ? mx_r : my_r;
    cur_sel = (st_r == ST_DIVX) ? cx_r : cy_r;
    sz_sel  = (st_r == ST_DIVX) ? w_e : h_e;
    off_s   = $signed({1'b0, cur_sel, 1'b0}) - $signed({2'b0, sz_sel});
    prod    = 47'(off_s) * $signed({15'b0, mass_r});
    nsx     = $signed({6'b0, mom_sel, 1'b0}) + prod;
    nneg    = nsx[46];
    nmag    = nneg ? 46'(-nsx) : 46'(nsx);
    d2      = {1'b0, mass_r, 1'b0};
    // round half away: (2|n| + d) / (2d)
    dnum    = DIV_NW'({nmag, 1'b0} + 47'(d2));
    dden    = {mass_r, 2'b0};
  end

  always_comb begin
    st_nxt = st_r; cx_nxt = cx_r; cy_nxt = cy_r; ix_nxt = ix_r; iy_nxt = iy_r;
    px_nxt = px_r; py_nxt = py_r; pv_nxt = 1'b0; it_nxt = it_r;
    mass_nxt = mass_r; mx_nxt = mx_r; my_nxt = my_r; tx_nxt = tx_r; txn_nxt = txn_r;
    ox_nxt = ox_r; oy_nxt = oy_r; out_v_nxt = out_v_r;
    mem_we = 1'b0;
    mem_wa = {RB'(in_sample_row), CB'(in_sample_col)};
    mem_ra = {RB'(cy_r + iy_r), CB'(cx_r + ix_r)};
    dctl.start = 1'b0;
    q_s = '0; tx_s = '0; adx = '0; ady = '0; accept_mv = 1'b0;

    if (out_v_r && !out_stall) out_v_nxt = 1'b0;

    // accumulate the sample read last cycle
    if (pv_r) begin
      mass_nxt = mass_r + 32'(rd_q);
      mx_nxt   = mx_r + 40'(px_r) * 40'(rd_q);
      my_nxt   = my_r + 40'(py_r) * 40'(rd_q);
    end

    case (st_r)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          if (in_action == ACT_WRITE) begin
            mem_we = (CWB'(in_sample_col) < CWB'(MAP_COLS_MAX)) &&
                     (RWB'(in_sample_row) < RWB'(MAP_ROWS_MAX));
          end else begin
            cx_nxt = (13'(in_start_x) > xmax) ? xmax : 13'(in_start_x);
            cy_nxt = (13'(in_start_y) > ymax) ? ymax : 13'(in_start_y);
            it_nxt = '0;
            st_nxt = ST_UPDATE;
            txn_nxt = 1'b1;   // marks entry: no move to apply
          end
        end
      end
      ST_ISSUE: begin
        pv_nxt = 1'b1;
        px_nxt = ix_r;
        py_nxt = iy_r;
        if (ix_r == w_e - 13'd1) begin
          ix_nxt = '0;
          if (iy_r == h_e - 13'd1) st_nxt = ST_DRAIN;
          else iy_nxt = iy_r + 13'd1;
        end else begin
          ix_nxt = ix_r + 13'd1;
        end
      end
      ST_DRAIN: begin
        // last sample lands this cycle, so test the completed sum
        if (mass_nxt == '0) begin
          it_nxt = it_r + 8'd1;
          st_nxt = ST_UPDATE;
          txn_nxt = 1'b1;
        end else begin
          st_nxt = ST_DIVX;
        end
      end
      ST_DIVX: begin
        dctl.start = 1'b1;
        txn_nxt = nneg;
        st_nxt = ST_WAITX;
      end
      ST_WAITX: begin
        if (dsts.done) begin
          tx_nxt = dquo[12:0];
          st_nxt = ST_DIVY;
        end
      end
      ST_DIVY: begin
        dctl.start = 1'b1;
        // y sign held in oy_r until the run's result is formed
        oy_nxt = {7'b0, nneg};
        st_nxt = ST_WAITY;
      end
      ST_WAITY: begin
        if (dsts.done) begin
          tx_s = txn_r ? -$signed({3'b0, tx_r}) : $signed({3'b0, tx_r});
          q_s  = oy_r[0] ? -$signed({3'b0, dquo[12:0]}) : $signed({3'b0, dquo[12:0]});
          adx  = 14'(tx_s > $signed({3'b0, cx_r}) ? tx_s - $signed({3'b0, cx_r})
                                                   : $signed({3'b0, cx_r}) - tx_s);
          ady  = 14'(q_s > $signed({3'b0, cy_r}) ? q_s - $signed({3'b0, cy_r})
                                                  : $signed({3'b0, cy_r}) - q_s);
          accept_mv = !tx_s[15] && !q_s[15] && (dquo[DIV_NW-1:13] == '0) &&
                      adx < 14'(w_e) && ady < 14'(h_e);
          if (accept_mv) begin
            cx_nxt = (tx_r > xmax) ? xmax : tx_r;
            cy_nxt = (dquo[12:0] > ymax) ? ymax : dquo[12:0];
          end
          it_nxt = it_r + 8'd1;
          txn_nxt = 1'b1;
          st_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // start next iteration or finish
        if (it_r == iters_r) begin
          st_nxt = ST_OUT;
        end else begin
          ix_nxt = '0; iy_nxt = '0;
          mass_nxt = '0; mx_nxt = '0; my_nxt = '0;
          st_nxt = ST_ISSUE;
        end
      end
      ST_OUT: begin
        if (!out_v_r) begin
          ox_nxt = cx_r[7:0];
          oy_nxt = cy_r[7:0];
          out_v_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      out_v_r <= 1'b0;
      pv_r    <= 1'b0;
      cx_r <= '0; cy_r <= '0; it_r <= '0;
    end else begin
      st_r    <= st_nxt;
      out_v_r <= out_v_nxt;
      pv_r    <= pv_nxt;
      cx_r <= cx_nxt; cy_r <= cy_nxt; it_r <= it_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ix_r <= ix_nxt; iy_r <= iy_nxt; px_r <= px_nxt; py_r <= py_nxt;
    mass_r <= mass_nxt; mx_r <= mx_nxt; my_r <= my_nxt;
    tx_r <= tx_nxt; txn_r <= txn_nxt; ox_r <= ox_nxt; oy_r <= oy_nxt;
  end

  mswt_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (dctl),
    .num  (dnum),
    .den  (dden),
    .sts  (dsts),
    .quo  (dquo)
  );

  // a result appears only at the end of a run
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(st_r) == ST_OUT)
    else $error("result without run");
  // no item is taken while a run is active
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> in_stall)
    else $error("item accepted during run");
  // the corner stays inside the map between iterations
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_ISSUE) |-> (cx_r <= xmax && cy_r <= ymax))
    else $error("corner outside map");

endmodule : mean_shift_window_tracker_core
`default_nettype wire
